### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Types, opcodes and sizing constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int FIFO_DEPTH_DEF  = 4;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_16 = 7'd126;
  localparam logic [6:0] LEN_64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_MSG_BYTE  = 3'd0,
    KIND_MSG_END   = 3'd1,
    KIND_PING_BYTE = 3'd2,
    KIND_PING_END  = 3'd3,
    KIND_CLOSE     = 3'd4
  } kind_t;

  // One queued result: the raw byte travels with its key byte, and the
  // back end applies the mask.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic       masked;
    logic       bin;
    logic       last;
  } item_t;

endpackage

### hdl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Walks the frame header byte by byte and classifies every payload byte.
// ----------------------------------------------------------------------------
module wsfd_parser #(
  parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output wsfd_pkg::item_t   item
);

  localparam int LB = LENGTH_BITS;

  wsfd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]    op_r, op_nxt;
  logic          fin_r, fin_nxt;
  logic          masked_r, masked_nxt;
  logic [3:0]    ext_r, ext_nxt;
  logic [LB-1:0] rem_r, rem_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic          act_r, act_nxt;
  logic          bin_r, bin_nxt;
  logic          closed_r, closed_nxt;

  logic          step;
  logic          hd;
  logic [3:0]    ext_dec;
  logic [LB-1:0] rem_dec;
  logic          data_end;
  logic          is_data;
  logic          e_msg_byte, e_msg_end, e_ping_byte, e_ping_end, e_close;
  logic          hd_act;

  assign step    = accept && !closed_r;
  assign ext_dec = ext_r - {3'd0, (ext_r != 4'd0)};
  assign rem_dec = rem_r - {{(LB-1){1'b0}}, (rem_r != '0)};
  assign data_end = (rem_dec == '0);
  assign is_data = (op_r inside {wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BIN});

  // Datapath registers and result classification.
  always_comb begin
    op_nxt      = op_r;
    fin_nxt     = fin_r;
    masked_nxt  = masked_r;
    ext_nxt     = ext_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    act_nxt     = act_r;
    bin_nxt     = bin_r;
    closed_nxt  = closed_r;
    hd          = 1'b0;
    e_msg_byte  = 1'b0;
    e_msg_end   = 1'b0;
    e_ping_byte = 1'b0;
    e_ping_end  = 1'b0;
    e_close     = 1'b0;
    hd_act      = act_r;
    if (step) begin
      case (phase_r)
        wsfd_pkg::PH_HDR0: begin
          op_nxt  = rx_byte[3:0];
          fin_nxt = rx_byte[7];
        end
        wsfd_pkg::PH_HDR1: begin
          if (op_r == wsfd_pkg::OP_CLOSE) begin
            closed_nxt = 1'b1;
            e_close    = 1'b1;
          end else begin
            if (op_r inside {wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BIN}) begin
              act_nxt = 1'b1;
              bin_nxt = (op_r == wsfd_pkg::OP_BIN);
            end
            masked_nxt = rx_byte[7];
            key_nxt    = '0;
            if (rx_byte[6:0] >= wsfd_pkg::LEN_16) begin
              ext_nxt = (rx_byte[6:0] == wsfd_pkg::LEN_64) ? wsfd_pkg::EXT64_BYTES
                                                           : wsfd_pkg::EXT16_BYTES;
              rem_nxt = '0;
            end else begin
              rem_nxt = {{(LB-7){1'b0}}, rx_byte[6:0]};
              if (rx_byte[7]) begin
                ext_nxt = wsfd_pkg::KEY_BYTES;
              end else begin
                hd = 1'b1;
              end
            end
          end
        end
        wsfd_pkg::PH_EXT: begin
          // A length too wide for the counter sticks at its largest value.
          if (rem_r[LB-1 -: 8] != 8'd0) begin
            rem_nxt = '1;
          end else begin
            rem_nxt = {rem_r[LB-9:0], rx_byte};
          end
          ext_nxt = ext_dec;
          if (ext_dec == 4'd0) begin
            if (masked_r) begin
              ext_nxt = wsfd_pkg::KEY_BYTES;
            end else begin
              hd = 1'b1;
            end
          end
        end
        wsfd_pkg::PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          ext_nxt = ext_dec;
          if (ext_dec == 4'd0) begin
            hd = 1'b1;
          end
        end
        wsfd_pkg::PH_DATA: begin
          pos_nxt = pos_r + 2'd1;
          rem_nxt = rem_dec;
          if (is_data && act_r) begin
            e_msg_byte = 1'b1;
            if (data_end && fin_r) begin
              act_nxt = 1'b0;
            end
          end else if (op_r == wsfd_pkg::OP_PING) begin
            e_ping_byte = 1'b1;
          end
        end
        default: ;
      endcase
      // End of header: an empty frame may report its end right away.
      if (hd) begin
        pos_nxt = 2'd0;
        hd_act  = act_nxt;
        if (rem_nxt == '0) begin
          if (is_data && hd_act && fin_r) begin
            e_msg_end = 1'b1;
            act_nxt   = 1'b0;
          end else if (op_r == wsfd_pkg::OP_PING) begin
            e_ping_end = 1'b1;
          end
        end
      end
    end
  end

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        wsfd_pkg::PH_HDR0: phase_nxt = wsfd_pkg::PH_HDR1;
        wsfd_pkg::PH_HDR1: begin
          if (op_r != wsfd_pkg::OP_CLOSE) begin
            if (rx_byte[6:0] >= wsfd_pkg::LEN_16) begin
              phase_nxt = wsfd_pkg::PH_EXT;
            end else if (rx_byte[7]) begin
              phase_nxt = wsfd_pkg::PH_MASK;
            end
          end
        end
        wsfd_pkg::PH_EXT: begin
          if (ext_dec == 4'd0 && masked_r) begin
            phase_nxt = wsfd_pkg::PH_MASK;
          end
        end
        wsfd_pkg::PH_DATA: begin
          if (data_end) begin
            phase_nxt = wsfd_pkg::PH_HDR0;
          end
        end
        default: phase_nxt = phase_r;
      endcase
      if (hd) begin
        phase_nxt = (rem_nxt != '0) ? wsfd_pkg::PH_DATA : wsfd_pkg::PH_HDR0;
      end
    end
  end

  // Result item toward the queue.
  always_comb begin
    push        = e_msg_byte || e_msg_end || e_ping_byte || e_ping_end || e_close;
    item.raw    = 8'd0;
    item.key    = 8'd0;
    item.masked = 1'b0;
    item.bin    = 1'b0;
    item.last   = 1'b1;
    item.kind   = wsfd_pkg::KIND_CLOSE;
    if (e_msg_byte) begin
      item.kind   = wsfd_pkg::KIND_MSG_BYTE;
      item.raw    = rx_byte;
      item.key    = key_r[8*(3-pos_r) +: 8];
      item.masked = masked_r;
      item.bin    = bin_r;
      item.last   = data_end && fin_r;
    end else if (e_ping_byte) begin
      item.kind   = wsfd_pkg::KIND_PING_BYTE;
      item.raw    = rx_byte;
      item.key    = key_r[8*(3-pos_r) +: 8];
      item.masked = masked_r;
      item.last   = data_end;
    end else if (e_msg_end) begin
      item.kind = wsfd_pkg::KIND_MSG_END;
      item.bin  = bin_nxt;
    end else if (e_ping_end) begin
      item.kind = wsfd_pkg::KIND_PING_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsfd_pkg::PH_HDR0;
      op_r     <= 4'd0;
      fin_r    <= 1'b0;
      masked_r <= 1'b0;
      ext_r    <= 4'd0;
      rem_r    <= '0;
      key_r    <= 32'd0;
      pos_r    <= 2'd0;
      act_r    <= 1'b0;
      bin_r    <= 1'b0;
      closed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      op_r     <= op_nxt;
      fin_r    <= fin_nxt;
      masked_r <= masked_nxt;
      ext_r    <= ext_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      act_r    <= act_nxt;
      bin_r    <= bin_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

### hdl/wsfd_fifo.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder result queue
// Short first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsfd_fifo #(
  parameter int DEPTH = wsfd_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsfd_pkg::item_t push_item,
  input  logic            pop,
  output wsfd_pkg::item_t head_item,
  output logic            empty,
  output logic            full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  wsfd_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == DEPTH_C);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST_IDX) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST_IDX) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hdl/wsfd_out.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder output stage
// Unmasks queued payload bytes and holds the result beat for the receiver.
// ----------------------------------------------------------------------------
module wsfd_out (
  input  logic            clk,
  input  logic            rst_n,
  input  wsfd_pkg::item_t head_item,
  input  logic            empty,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_out_byte,
  output logic            out_binary_msg,
  output logic            out_last
);

  logic       valid_r;
  logic [2:0] kind_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bin_r;
  logic       last_r;
  logic       load;

  assign load = !empty && (!valid_r || !out_stall);
  assign pop  = load;

  always_comb begin
    byte_nxt = 8'd0;
    if (head_item.kind == wsfd_pkg::KIND_MSG_BYTE ||
        head_item.kind == wsfd_pkg::KIND_PING_BYTE) begin
      byte_nxt = head_item.masked ? (head_item.raw ^ head_item.key) : head_item.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head_item.kind;
      byte_r <= byte_nxt;
      bin_r  <= head_item.bin;
      last_r <= head_item.last;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_out_byte   = byte_r;
  assign out_binary_msg = bin_r;
  assign out_last       = last_r;

endmodule

### hdl/websocket_frame_decoder.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder
// Parses a received WebSocket byte stream and delivers unmasked payload beats.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                                   Beat
//  in       input      in_valid, in_stall, in_rx_byte          one stream byte
//  out      output     out_valid, out_stall, out_kind,         one result
//                      out_out_byte, out_binary_msg, out_last
//
//  One byte is taken every cycle while in_stall is low; the parser state
//  machine handles each byte as it is taken. A result passes through the
//  queue and then the output register. in_stall rises only when the result
//  queue is full, which happens once FIFO_DEPTH results wait behind a beat that
//  out_stall holds in the output register.
//  Reset is synchronous and active low; there is no clearing pass.
// ----------------------------------------------------------------------------
module websocket_frame_decoder #(
  parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF,
  parameter int FIFO_DEPTH  = wsfd_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_binary_msg,
  output logic       out_last
);

  wsfd_pkg::item_t push_item, head_item;
  logic push, pop, empty, full;

  assign in_stall = full;

  wsfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_valid && !in_stall),
    .rx_byte(in_rx_byte),
    .push   (push),
    .item   (push_item)
  );

  wsfd_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head_item(head_item),
    .empty    (empty),
    .full     (full)
  );

  wsfd_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_item     (head_item),
    .empty         (empty),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_out_byte  (out_out_byte),
    .out_binary_msg(out_binary_msg),
    .out_last      (out_last)
  );

endmodule

### hdl/wsfd_checker.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_kind,
  input logic [7:0] out_out_byte,
  input logic       out_binary_msg,
  input logic       out_last
);

  logic        closed_seen_r;
  logic        end_kind;
  logic        ctrl_kind;
  logic [12:0] out_pay;

  assign end_kind = (out_kind == wsfd_pkg::KIND_MSG_END) ||
                    (out_kind == wsfd_pkg::KIND_PING_END) ||
                    (out_kind == wsfd_pkg::KIND_CLOSE);
  assign ctrl_kind = (out_kind >= wsfd_pkg::KIND_PING_BYTE);
  assign out_pay   = {out_kind, out_out_byte, out_binary_msg, out_last};

  // Remembers that the close beat has been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_kind == wsfd_pkg::KIND_CLOSE) begin
      closed_seen_r <= 1'b1;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pay))
  `ASSERT_IMPL(a_end_form, clk, rst_n, out_valid && end_kind, out_last && out_out_byte == 8'd0)
  `ASSERT_IMPL(a_ctrl_text, clk, rst_n, out_valid && ctrl_kind, !out_binary_msg)
  `ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_kind <= wsfd_pkg::KIND_CLOSE)
  `ASSERT_IMPL(a_close_final, clk, rst_n, out_valid, !closed_seen_r)

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (.*);

### sim/tb_websocket_frame_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame decoder testbench
// Feeds framed byte streams into the decoder, predicts each result beat with
// an independent frame parser, and checks every beat that leaves the block.
// Covers data, control, fragmented, truncated and extended-length frames
// under random idling on both channels and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_websocket_frame_decoder;

  localparam logic [3:0] OP_PONG        = 4'hA;
  localparam logic [3:0] OP_NC_FIRST    = 4'h3;
  localparam logic [3:0] OP_NC_LAST     = 4'h7;
  localparam logic [3:0] OP_CTL_FIRST   = 4'hB;
  localparam logic [3:0] OP_CTL_LAST    = 4'hF;
  localparam logic [63:0] LEN_LIMIT     = {64{1'b1}} >> (64 - wsfd_pkg::LENGTH_BITS_DEF);
  localparam int FILL_RANDOM            = -1;
  localparam int QUIET_LIMIT            = 1000;
  localparam int HOLD_CYCLES            = 200;
  localparam int DRAIN_CYCLES           = 10;

  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  typedef struct {
    wsfd_pkg::kind_t kind;
    logic [7:0]      data;
    logic            bin;
    logic            last;
  } decoded_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_kind;
  logic [7:0] out_out_byte;
  logic       out_binary_msg;
  logic       out_last;

  // Parser state of the predictor.
  wsfd_pkg::phase_t dec_phase;
  logic [3:0]  dec_opcode;
  logic        dec_fin;
  logic        dec_masked;
  logic [3:0]  dec_ext_left;
  logic [63:0] dec_len_left;
  logic [31:0] dec_key;
  logic [1:0]  dec_key_pos;
  logic        msg_open;
  logic        msg_bin;
  logic        stream_closed;

  decoded_t    decoded_q[$];
  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  bit          close_allowed;

  websocket_frame_decoder DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_out_byte  (out_out_byte),
    .out_binary_msg(out_binary_msg),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic queue_result(input wsfd_pkg::kind_t k, input logic [7:0] d,
                              input logic bin, input logic last);
    decoded_t beat;
    beat.kind = k;
    beat.data = d;
    beat.bin  = bin;
    beat.last = last;
    decoded_q.push_back(beat);
  endtask

  task automatic finish_header();
    dec_key_pos = '0;
    if (dec_len_left != 0) begin
      dec_phase = wsfd_pkg::PH_DATA;
    end else begin
      dec_phase = wsfd_pkg::PH_HDR0;
      if (dec_opcode <= wsfd_pkg::OP_BIN && msg_open && dec_fin) begin
        queue_result(wsfd_pkg::KIND_MSG_END, 8'h00, msg_bin, 1'b1);
        msg_open = 1'b0;
      end else if (dec_opcode == wsfd_pkg::OP_PING) begin
        queue_result(wsfd_pkg::KIND_PING_END, 8'h00, 1'b0, 1'b1);
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0] v;
    logic       at_end;
    if (!stream_closed) begin
      case (dec_phase)
        wsfd_pkg::PH_HDR0: begin
          dec_opcode = b[3:0];
          dec_fin    = b[7];
          dec_phase  = wsfd_pkg::PH_HDR1;
        end
        wsfd_pkg::PH_HDR1: begin
          if (dec_opcode == wsfd_pkg::OP_CLOSE) begin
            stream_closed = 1'b1;
            queue_result(wsfd_pkg::KIND_CLOSE, 8'h00, 1'b0, 1'b1);
          end else begin
            if (dec_opcode == wsfd_pkg::OP_TEXT || dec_opcode == wsfd_pkg::OP_BIN) begin
              msg_open = 1'b1;
              msg_bin  = (dec_opcode == wsfd_pkg::OP_BIN);
            end
            dec_masked = b[7];
            dec_key    = '0;
            if (b[6:0] >= wsfd_pkg::LEN_16) begin
              dec_ext_left = (b[6:0] == wsfd_pkg::LEN_64) ? wsfd_pkg::EXT64_BYTES
                                                          : wsfd_pkg::EXT16_BYTES;
              dec_len_left = '0;
              dec_phase    = wsfd_pkg::PH_EXT;
            end else begin
              dec_len_left = 64'(b[6:0]);
              if (dec_masked) begin
                dec_ext_left = wsfd_pkg::KEY_BYTES;
                dec_phase    = wsfd_pkg::PH_MASK;
              end else begin
                finish_header();
              end
            end
          end
        end
        wsfd_pkg::PH_EXT: begin
          // Lengths too wide for the counter pin at its maximum.
          if (dec_len_left > (LEN_LIMIT >> 8))
            dec_len_left = LEN_LIMIT;
          else
            dec_len_left = ((dec_len_left << 8) | 64'(b)) & LEN_LIMIT;
          if (dec_ext_left != 0) dec_ext_left--;
          if (dec_ext_left == 0) begin
            if (dec_masked) begin
              dec_ext_left = wsfd_pkg::KEY_BYTES;
              dec_phase    = wsfd_pkg::PH_MASK;
            end else begin
              finish_header();
            end
          end
        end
        wsfd_pkg::PH_MASK: begin
          dec_key = {dec_key[23:0], b};
          if (dec_ext_left != 0) dec_ext_left--;
          if (dec_ext_left == 0) finish_header();
        end
        wsfd_pkg::PH_DATA: begin
          v = b;
          if (dec_masked) v = b ^ dec_key[8 * (3 - int'(dec_key_pos)) +: 8];
          dec_key_pos++;
          if (dec_len_left != 0) dec_len_left--;
          at_end = (dec_len_left == 0);
          if (at_end) dec_phase = wsfd_pkg::PH_HDR0;
          if (dec_opcode <= wsfd_pkg::OP_BIN && msg_open) begin
            queue_result(wsfd_pkg::KIND_MSG_BYTE, v, msg_bin, at_end && dec_fin);
            if (at_end && dec_fin) msg_open = 1'b0;
          end else if (dec_opcode == wsfd_pkg::OP_PING) begin
            queue_result(wsfd_pkg::KIND_PING_BYTE, v, 1'b0, at_end);
          end
        end
        default: dec_phase = wsfd_pkg::PH_HDR0;
      endcase
    end
  endtask

  // ------------------------------------------------------------------ drivers

  task automatic send_byte(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    // Close ends the stream for good, so it is held back until the last test.
    if (!close_allowed && dec_phase == wsfd_pkg::PH_HDR0 && v[3:0] == wsfd_pkg::OP_CLOSE)
      v[0] = 1'b1;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= v;
    do @(posedge clk); while (in_stall);
    decode_byte(v);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] opc, input bit fin, input bit masked,
                            input logic [2:0] rsv, input int unsigned len,
                            input len_form_t form, input int fill, input int keep);
    logic [7:0]  wire_q[$];
    logic [63:0] len64;
    int          n;
    len64 = 64'(len);
    wire_q.push_back({fin, rsv, opc});
    case (form)
      LEN_SHORT: wire_q.push_back({masked, len64[6:0]});
      LEN_EXT16: begin
        wire_q.push_back({masked, wsfd_pkg::LEN_16});
        wire_q.push_back(len64[15:8]);
        wire_q.push_back(len64[7:0]);
      end
      default: begin
        wire_q.push_back({masked, wsfd_pkg::LEN_64});
        for (int i = 7; i >= 0; i--) wire_q.push_back(len64[8 * i +: 8]);
      end
    endcase
    if (masked) repeat (4) wire_q.push_back(8'($urandom));
    for (int unsigned i = 0; i < len; i++)
      wire_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    n = (keep < 0 || keep > wire_q.size()) ? wire_q.size() : keep;
    for (int i = 0; i < n; i++) send_byte(wire_q[i]);
  endtask

  // After noise or a cut frame, walk the parser back to a header boundary
  // while keeping any length it picks up small.
  task automatic resync_stream();
    logic [7:0] b;
    while (dec_phase != wsfd_pkg::PH_HDR0) begin
      b = 8'($urandom);
      if (dec_phase == wsfd_pkg::PH_HDR1) b[6:0] = 7'($urandom_range(20));
      if (dec_phase == wsfd_pkg::PH_EXT) b = 8'h00;
      send_byte(b);
    end
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("beat with nothing pending, kind", 32'd0, 32'(out_kind));
      end else begin
        want = decoded_q.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", 32'(want.kind), 32'(out_kind));
        if (out_out_byte !== want.data)
          report_mismatch("byte", 32'(want.data), 32'(out_out_byte));
        if (out_binary_msg !== want.bin)
          report_mismatch("binary_msg", 32'(want.bin), 32'(out_binary_msg));
        if (out_last !== want.last)
          report_mismatch("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel is a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ERROR watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_data_frames();
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b0, 3'b000, 3, LEN_SHORT, 0, -1);
    send_frame(wsfd_pkg::OP_BIN, 1'b1, 1'b1, 3'b111, 5, LEN_SHORT, 255, -1);
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b0, 3'b000, 0, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_BIN, 1'b1, 1'b1, 3'b010, 0, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b1, 3'b000, 9, LEN_SHORT, FILL_RANDOM, -1);
  endtask

  task automatic test_control_frames();
    send_frame(wsfd_pkg::OP_PING, 1'b1, 1'b0, 3'b000, 0, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_PING, 1'b0, 1'b1, 3'b101, 2, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(OP_PONG, 1'b1, 1'b1, 3'b000, 3, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(OP_PONG, 1'b1, 1'b0, 3'b000, 0, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(OP_NC_FIRST, 1'b1, 1'b0, 3'b000, 2, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(OP_CTL_LAST, 1'b1, 1'b1, 3'b000, 4, LEN_SHORT, FILL_RANDOM, -1);
  endtask

  task automatic test_fragmentation();
    // Control frames in the middle of a message leave it open.
    send_frame(wsfd_pkg::OP_TEXT, 1'b0, 1'b0, 3'b000, 2, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_PING, 1'b1, 1'b1, 3'b000, 2, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(OP_PONG, 1'b1, 1'b0, 3'b000, 1, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_CONT, 1'b0, 1'b0, 3'b000, 0, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_CONT, 1'b1, 1'b1, 3'b000, 3, LEN_SHORT, FILL_RANDOM, -1);
    // A new data frame drops the unfinished message.
    send_frame(wsfd_pkg::OP_BIN, 1'b0, 1'b0, 3'b000, 2, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b0, 3'b000, 1, LEN_SHORT, FILL_RANDOM, -1);
    // Continuations with no message open are skipped.
    send_frame(wsfd_pkg::OP_CONT, 1'b1, 1'b1, 3'b000, 3, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_CONT, 1'b1, 1'b0, 3'b000, 0, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_BIN, 1'b0, 1'b0, 3'b000, 1, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_CONT, 1'b1, 1'b0, 3'b000, 0, LEN_SHORT, FILL_RANDOM, -1);
  endtask

  task automatic test_extended_lengths();
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b1, 3'b000, 4, LEN_EXT16, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_BIN, 1'b1, 1'b0, 3'b000, 130, LEN_EXT16, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b1, 3'b000, 3, LEN_EXT64, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_PING, 1'b1, 1'b0, 3'b000, 0, LEN_EXT64, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b1, 3'b000, 0, LEN_EXT16, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_BIN, 1'b1, 1'b0, 3'b000, 30, LEN_EXT64, FILL_RANDOM, -1);
  endtask

  task automatic test_random_stream(input int unsigned count, input int send_pct,
                                    input int recv_pct);
    int unsigned start;
    int unsigned len;
    int          r;
    int          keep;
    logic [3:0]  opc;
    len_form_t   form;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      r = $urandom_range(99);
      if (msg_open && r < 40) begin
        opc = wsfd_pkg::OP_CONT;
      end else begin
        r = $urandom_range(99);
        if (r < 30) opc = $urandom_range(1) ? wsfd_pkg::OP_BIN : wsfd_pkg::OP_TEXT;
        else if (r < 45) opc = wsfd_pkg::OP_CONT;
        else if (r < 62) opc = wsfd_pkg::OP_PING;
        else if (r < 72) opc = OP_PONG;
        else if (r < 80) opc = 4'($urandom_range(OP_NC_LAST, OP_NC_FIRST));
        else if (r < 86) opc = 4'($urandom_range(OP_CTL_LAST, OP_CTL_FIRST));
        else opc = $urandom_range(1) ? wsfd_pkg::OP_BIN : wsfd_pkg::OP_TEXT;
      end
      r = $urandom_range(99);
      if (r < 4) begin
        form = LEN_EXT64;
        len  = $urandom_range(40);
      end else if (r < 14) begin
        form = LEN_EXT16;
        len  = $urandom_range(140);
      end else begin
        form = LEN_SHORT;
        len  = $urandom_range(12);
      end
      r = $urandom_range(99);
      if (r < 6) begin
        send_byte(8'($urandom));
      end else begin
        keep = (r < 14) ? int'($urandom_range(5 + len, 1)) : -1;
        send_frame(opc, 1'($urandom_range(99) < 60), 1'($urandom_range(1)), 3'($urandom),
                   len, form, FILL_RANDOM, keep);
      end
      resync_stream();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b1, 3'b000, 40, LEN_SHORT, FILL_RANDOM, -1);
  endtask

  task automatic test_close();
    close_allowed = 1'b1;
    send_frame(wsfd_pkg::OP_CLOSE, 1'b1, 1'b1, 3'b000, 2, LEN_SHORT, FILL_RANDOM, -1);
    // Everything after the close is dropped by the block.
    send_frame(wsfd_pkg::OP_TEXT, 1'b1, 1'b0, 3'b000, 3, LEN_SHORT, FILL_RANDOM, -1);
    send_frame(wsfd_pkg::OP_PING, 1'b1, 1'b0, 3'b000, 0, LEN_SHORT, FILL_RANDOM, -1);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    error_count   = 0;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    hold_left     = 0;
    close_allowed = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 84;
    dec_phase     = wsfd_pkg::PH_HDR0;
    dec_opcode    = '0;
    dec_fin       = 1'b0;
    dec_masked    = 1'b0;
    dec_ext_left  = '0;
    dec_len_left  = '0;
    dec_key       = '0;
    dec_key_pos   = '0;
    msg_open      = 1'b0;
    msg_bin       = 1'b0;
    stream_closed = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_data_frames();
    test_control_frames();
    test_fragmentation();
    test_extended_lengths();
    test_random_stream(50, 29, 84);
    test_random_stream(50, 84, 29);
    test_backpressure();
    test_random_stream(45, 0, 0);
    test_close();

    @(negedge clk);
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
